// File: rtl/core/irpd_pkg.sv
// Package with the types, register codes and helper function of the IR pulse distance transmitter.
`timescale 1ns / 1ps
`default_nettype none
package irpd_pkg;

	localparam int CODE_W      = 32;
	localparam int COUNT_W     = 6;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int POS_W       = 5;

	localparam int RESET_START_MARK_US  = 9000;
	localparam int RESET_START_SPACE_US = 4500;
	localparam int RESET_BIT_MARK_US    = 560;
	localparam int RESET_ONE_SPACE_US   = 1690;
	localparam int RESET_ZERO_SPACE_US  = 560;
	localparam int RESET_END_MARK_US    = 560;
	localparam int RESET_END_SPACE_US   = 0;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SEND = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_MARK  = 3'd0,
		REG_START_SPACE = 3'd1,
		REG_BIT_MARK    = 3'd2,
		REG_ONE_SPACE   = 3'd3,
		REG_ZERO_SPACE  = 3'd4,
		REG_END_MARK    = 3'd5,
		REG_END_SPACE   = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEG_IDLE,
		SEG_START,
		SEG_BIT,
		SEG_END
	} seg_t;

	typedef struct packed {
		logic               op;
		logic [CODE_W-1:0]  code_word;
		logic [COUNT_W-1:0] bit_count;
	} in_item_t;

	typedef struct packed {
		logic ir_level;
		logic busy_res;
		logic rejected;
		logic frame_done;
	} out_item_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  value;
	} cfg_item_t;

	// Position of the highest set bit, found by halving the word five times.
	function automatic logic [POS_W-1:0] msb_index(input logic [CODE_W-1:0] vec);
		logic [CODE_W-1:0] w;
		logic [POS_W-1:0]  idx;
		w   = vec;
		idx = '0;
		for (int k = POS_W - 1; k >= 0; k--) begin
			if ((w >> (1 << k)) != '0) begin
				idx[k] = 1'b1;
				w      = w >> (1 << k);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/irpd_if.sv
// Valid/ready channel interfaces for send and tick items, result items and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface irpd_in_if;
	logic               valid;
	logic               ready;
	irpd_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface irpd_out_if;
	logic                valid;
	logic                ready;
	irpd_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface irpd_cfg_if;
	logic                valid;
	logic                ready;
	irpd_pkg::cfg_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ir_pulse_distance_transmitter_core.sv
// Top level of the IR pulse distance transmitter: frame sequencer, carrier and result buffer.
//
// The item channel takes one send or tick item per transfer. A send item loads a code
// word and bit count and starts a frame; each tick item is one microsecond of output
// and returns the pin level. Every item gives exactly one result item on the result
// channel, in order. The next state and the result are worked out in the cycle an
// item is taken and registered into the result buffer, and one item can be taken
// every cycle while the buffer has room. A two-entry result buffer decouples the
// channels: while the receiver stalls, items are still taken until both entries are
// full, then the item channel holds ready low until a result leaves. The register
// channel is always ready; the carrier count of each mark register is computed when
// it is written. Reset returns the registers to their default timings, idles the
// sequencer and empties the result buffer.
`timescale 1ns / 1ps
`default_nettype none
module ir_pulse_distance_transmitter_core #(
	parameter int CARRIER_PERIOD = 26,
	parameter int CARRIER_HIGH   = 9,
	parameter int TIME_BITS      = 16,
	parameter int MAX_BITS       = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	irpd_in_if.sink     item,
	irpd_out_if.source  result,
	irpd_cfg_if.sink    cfg
);
	import irpd_pkg::*;

	localparam int  TW       = (TIME_BITS < CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;
	localparam int  PW       = $clog2(CARRIER_PERIOD);
	localparam int  RL       = $clog2(CARRIER_PERIOD);
	localparam int  K        = TW + RL;
	localparam longint unsigned RECIP_L =
		((longint'(1) << K) + longint'(CARRIER_PERIOD) - 1) / longint'(CARRIER_PERIOD);
	localparam logic [K-1:0] RECIP = K'(RECIP_L);
	localparam int  TMOD     = 1 << TW;

	localparam logic [TW-1:0] RST_START_MARK  =
		TW'((RESET_START_MARK_US % TMOD) / CARRIER_PERIOD);
	localparam logic [TW-1:0] RST_START_SPACE = TW'(RESET_START_SPACE_US % TMOD);
	localparam logic [TW-1:0] RST_BIT_MARK    =
		TW'((RESET_BIT_MARK_US % TMOD) / CARRIER_PERIOD);
	localparam logic [TW-1:0] RST_ONE_SPACE   = TW'(RESET_ONE_SPACE_US % TMOD);
	localparam logic [TW-1:0] RST_ZERO_SPACE  = TW'(RESET_ZERO_SPACE_US % TMOD);
	localparam logic [TW-1:0] RST_END_MARK    =
		TW'((RESET_END_MARK_US % TMOD) / CARRIER_PERIOD);
	localparam logic [TW-1:0] RST_END_SPACE   = TW'(RESET_END_SPACE_US % TMOD);
	localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(MAX_BITS);

	// Timing registers; marks are held as whole carrier cycles.
	logic [TW-1:0] start_mark_q, start_space_q, bit_mark_q, one_space_q;
	logic [TW-1:0] zero_space_q, end_mark_q, end_space_q;

	// Frame state.
	seg_t               seg_q, seg_d;
	logic [CODE_W-1:0]  code_q, code_d;
	logic [COUNT_W-1:0] bits_q, bits_d;
	logic [TW-1:0]      mark_q, mark_d;
	logic [TW-1:0]      space_q, space_d;
	logic [PW-1:0]      phase_q, phase_d;

	// Result buffer.
	out_item_t  slot0_q, slot1_q;
	logic [1:0] cnt_q;
	out_item_t  res;

	logic push, pop;
	assign push = item.valid && item.ready;
	assign pop  = result.valid && result.ready;
	assign item.ready   = (cnt_q != 2'd2);
	assign result.valid = (cnt_q != 2'd0);
	assign result.data  = slot0_q;
	assign cfg.ready    = 1'b1;

	// Carrier cycles of a written mark, by reciprocal multiplication.
	logic [TW-1:0]   cfg_time;
	logic [TW+K-1:0] cfg_prod;
	logic [TW-1:0]   cfg_cycles;
	assign cfg_time   = cfg.data.value[TW-1:0];
	assign cfg_prod   = (TW+K)'(cfg_time) * (TW+K)'(RECIP);
	assign cfg_cycles = cfg_prod[TW+K-1:K];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_mark_q  <= RST_START_MARK;
			start_space_q <= RST_START_SPACE;
			bit_mark_q    <= RST_BIT_MARK;
			one_space_q   <= RST_ONE_SPACE;
			zero_space_q  <= RST_ZERO_SPACE;
			end_mark_q    <= RST_END_MARK;
			end_space_q   <= RST_END_SPACE;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.index)
				REG_START_MARK:  start_mark_q  <= cfg_cycles;
				REG_START_SPACE: start_space_q <= cfg_time;
				REG_BIT_MARK:    bit_mark_q    <= cfg_cycles;
				REG_ONE_SPACE:   one_space_q   <= cfg_time;
				REG_ZERO_SPACE:  zero_space_q  <= cfg_time;
				REG_END_MARK:    end_mark_q    <= cfg_cycles;
				REG_END_SPACE:   end_space_q   <= cfg_time;
				default: begin
				end
			endcase
		end
	end

	// Saturated bit count of a send item.
	logic [COUNT_W-1:0] n_sat;
	assign n_sat = (item.data.bit_count > MAX_COUNT) ? MAX_COUNT : item.data.bit_count;

	// One microsecond of the current pulse.
	logic          lvl;
	logic [TW-1:0] mark_t, space_t;
	logic [PW-1:0] phase_t;
	logic          pulse_end;

	always_comb begin
		lvl     = 1'b0;
		mark_t  = mark_q;
		space_t = space_q;
		phase_t = phase_q;
		if (mark_q != '0) begin
			lvl = (32'(phase_q) < 32'(CARRIER_HIGH));
			if (phase_q == PW'(CARRIER_PERIOD - 1)) begin
				phase_t = '0;
				mark_t  = mark_q - 1'b1;
			end else begin
				phase_t = phase_q + 1'b1;
			end
		end else begin
			space_t = space_q - 1'b1;
		end
		pulse_end = (mark_t == '0) && (space_t == '0);
	end

	// Next non-empty pulse after the current one, skipping empty pulses.
	logic               is_send;
	logic [CODE_W-1:0]  adv_code;
	logic [COUNT_W-1:0] adv_bits_in;
	logic               adv_from_end;
	logic               one_live, zero_live;
	logic [CODE_W-1:0]  live_vec;
	logic [POS_W-1:0]   live_pos;
	seg_t               adv_seg;
	logic [COUNT_W-1:0] adv_bits;
	logic [TW-1:0]      adv_mark, adv_space;

	assign is_send      = (item.data.op == OP_SEND);
	assign adv_code     = is_send ? item.data.code_word : code_q;
	assign adv_bits_in  = is_send ? n_sat : bits_q;
	assign adv_from_end = !is_send && (seg_q == SEG_END);
	assign one_live     = (bit_mark_q != '0) || (one_space_q != '0);
	assign zero_live    = (bit_mark_q != '0) || (zero_space_q != '0);

	always_comb begin
		for (int i = 0; i < CODE_W; i++) begin
			live_vec[i] = (COUNT_W'(i) < adv_bits_in) &&
				(adv_code[i] ? one_live : zero_live);
		end
	end

	assign live_pos = msb_index(live_vec);

	always_comb begin
		adv_seg   = SEG_IDLE;
		adv_bits  = adv_bits_in;
		adv_mark  = '0;
		adv_space = '0;
		if (!adv_from_end) begin
			if (live_vec != '0) begin
				adv_seg   = SEG_BIT;
				adv_bits  = COUNT_W'(live_pos);
				adv_mark  = bit_mark_q;
				adv_space = adv_code[live_pos] ? one_space_q : zero_space_q;
			end else if ((end_mark_q != '0) || (end_space_q != '0)) begin
				adv_seg   = SEG_END;
				adv_bits  = '0;
				adv_mark  = end_mark_q;
				adv_space = end_space_q;
			end
		end
	end

	// Next state of the sequencer.
	logic start_empty;
	assign start_empty = (start_mark_q == '0) && (start_space_q == '0);

	always_comb begin
		seg_d   = seg_q;
		code_d  = code_q;
		bits_d  = bits_q;
		mark_d  = mark_q;
		space_d = space_q;
		phase_d = phase_q;
		if (seg_q == SEG_IDLE) begin
			if (is_send) begin
				code_d  = item.data.code_word;
				phase_d = '0;
				if (!start_empty) begin
					seg_d   = SEG_START;
					bits_d  = n_sat;
					mark_d  = start_mark_q;
					space_d = start_space_q;
				end else begin
					seg_d   = adv_seg;
					bits_d  = adv_bits;
					mark_d  = adv_mark;
					space_d = adv_space;
				end
			end
		end else if (!is_send) begin
			if (!pulse_end) begin
				mark_d  = mark_t;
				space_d = space_t;
				phase_d = phase_t;
			end else begin
				seg_d   = adv_seg;
				bits_d  = adv_bits;
				mark_d  = adv_mark;
				space_d = adv_space;
				phase_d = '0;
			end
		end
	end

	// Result of the item.
	always_comb begin
		res = '0;
		if (seg_q == SEG_IDLE) begin
			if (is_send) begin
				res.busy_res = (seg_d != SEG_IDLE);
			end
		end else if (is_send) begin
			res.busy_res = 1'b1;
			res.rejected = 1'b1;
		end else begin
			res.busy_res   = 1'b1;
			res.ir_level   = lvl;
			res.frame_done = (seg_d == SEG_IDLE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q   <= SEG_IDLE;
			code_q  <= '0;
			bits_q  <= '0;
			mark_q  <= '0;
			space_q <= '0;
			phase_q <= '0;
		end else if (push) begin
			seg_q   <= seg_d;
			code_q  <= code_d;
			bits_q  <= bits_d;
			mark_q  <= mark_d;
			space_q <= space_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				slot0_q <= res;
			end else begin
				slot1_q <= res;
			end
		end else if (pop && !push) begin
			slot0_q <= slot1_q;
		end else if (push && pop) begin
			if (cnt_q == 2'd1) begin
				slot0_q <= res;
			end else begin
				slot0_q <= slot1_q;
				slot1_q <= res;
			end
		end
	end

endmodule
`default_nettype wire

// File: tb/ir_pulse_distance_transmitter_core_tb.sv
// Self-checking testbench of the IR pulse distance transmitter core with a frame-tracking scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module ir_pulse_distance_transmitter_core_tb;
	import irpd_pkg::*;

	localparam int CARRIER_PERIOD = 26;
	localparam int CARRIER_HIGH   = 9;
	localparam int TIME_BITS      = 16;
	localparam int MAX_BITS       = 32;
	localparam int NUM_TIMINGS    = 7;
	localparam int RANDOM_ITEMS   = 1250;
	localparam int CYCLE_LIMIT    = 500000;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	class frame_tracker;
		logic [CFG_DATA_W-1:0] timing [NUM_TIMINGS];
		seg_t                  part;
		logic [CODE_W-1:0]     code_bits;
		logic [COUNT_W-1:0]    bits_due;
		logic [15:0]           cycles_left;
		logic [15:0]           quiet_left;
		logic [4:0]            carrier_pos;
		out_item_t             results_due [$];
		int                    failures;
		int                    results_seen;

		function new();
			timing[REG_START_MARK]  = CFG_DATA_W'(RESET_START_MARK_US);
			timing[REG_START_SPACE] = CFG_DATA_W'(RESET_START_SPACE_US);
			timing[REG_BIT_MARK]    = CFG_DATA_W'(RESET_BIT_MARK_US);
			timing[REG_ONE_SPACE]   = CFG_DATA_W'(RESET_ONE_SPACE_US);
			timing[REG_ZERO_SPACE]  = CFG_DATA_W'(RESET_ZERO_SPACE_US);
			timing[REG_END_MARK]    = CFG_DATA_W'(RESET_END_MARK_US);
			timing[REG_END_SPACE]   = CFG_DATA_W'(RESET_END_SPACE_US);
			part         = SEG_IDLE;
			code_bits    = '0;
			bits_due     = '0;
			cycles_left  = '0;
			quiet_left   = '0;
			carrier_pos  = '0;
			failures     = 0;
			results_seen = 0;
		endfunction

		function void write_timing(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx <= REG_END_SPACE)
				timing[idx] = val;
		endfunction

		function void arm_pulse(logic [15:0] mark_us, logic [15:0] space_us);
			cycles_left = 16'(mark_us / CARRIER_PERIOD);
			quiet_left  = space_us;
			carrier_pos = '0;
		endfunction

		function void step_pulse();
			logic sent_one;
			if (part == SEG_START || part == SEG_BIT) begin
				if (bits_due != 0) begin
					sent_one  = code_bits[CODE_W-1];
					code_bits = code_bits << 1;
					bits_due  = bits_due - 1'b1;
					part      = SEG_BIT;
					arm_pulse(timing[REG_BIT_MARK],
						sent_one ? timing[REG_ONE_SPACE] : timing[REG_ZERO_SPACE]);
				end else begin
					part = SEG_END;
					arm_pulse(timing[REG_END_MARK], timing[REG_END_SPACE]);
				end
			end else begin
				part        = SEG_IDLE;
				cycles_left = '0;
				quiet_left  = '0;
				carrier_pos = '0;
			end
		endfunction

		function void drop_empty_pulses();
			while (part != SEG_IDLE && cycles_left == 0 && quiet_left == 0)
				step_pulse();
		endfunction

		function bit sending();
			return part != SEG_IDLE;
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		function void take_item(in_item_t it);
			out_item_t e;
			int        n;
			e = '0;
			if (it.op == OP_SEND) begin
				if (part != SEG_IDLE) begin
					e.rejected = 1'b1;
					e.busy_res = 1'b1;
				end else begin
					n = (it.bit_count > MAX_BITS) ? MAX_BITS : int'(it.bit_count);
					code_bits = (n > 0) ? (it.code_word << (CODE_W - n)) : '0;
					bits_due  = n[COUNT_W-1:0];
					part      = SEG_START;
					arm_pulse(timing[REG_START_MARK], timing[REG_START_SPACE]);
					drop_empty_pulses();
					e.busy_res = (part != SEG_IDLE);
				end
			end else begin
				drop_empty_pulses();
				if (part != SEG_IDLE) begin
					e.busy_res = 1'b1;
					if (cycles_left != 0) begin
						e.ir_level = (carrier_pos < CARRIER_HIGH);
						if (carrier_pos == CARRIER_PERIOD - 1) begin
							carrier_pos = '0;
							cycles_left = cycles_left - 1'b1;
						end else begin
							carrier_pos = carrier_pos + 1'b1;
						end
					end else begin
						quiet_left = quiet_left - 1'b1;
					end
					drop_empty_pulses();
					e.frame_done = (part == SEG_IDLE);
				end
			end
			results_due.insert(results_due.size(), e);
		endfunction

		function void match_result(out_item_t got);
			out_item_t e;
			results_seen++;
			if (results_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display({"result %0d arrived with nothing outstanding: ",
						"level %b busy %b rej %b done %b"},
						results_seen, got.ir_level, got.busy_res, got.rejected,
						got.frame_done);
				return;
			end
			e = results_due.pop_front();
			if (got.ir_level !== e.ir_level || got.busy_res !== e.busy_res ||
					got.rejected !== e.rejected || got.frame_done !== e.frame_done) begin
				failures++;
				if (failures <= 10)
					$display({"result %0d mismatch: level %b/%b busy %b/%b ",
						"rej %b/%b done %b/%b (exp/got)"},
						results_seen, e.ir_level, got.ir_level, e.busy_res, got.busy_res,
						e.rejected, got.rejected, e.frame_done, got.frame_done);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	irpd_in_if  item_ch ();
	irpd_out_if result_ch ();
	irpd_cfg_if cfg_ch ();

	ir_pulse_distance_transmitter_core #(
		.CARRIER_PERIOD(CARRIER_PERIOD),
		.CARRIER_HIGH  (CARRIER_HIGH),
		.TIME_BITS     (TIME_BITS),
		.MAX_BITS      (MAX_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	frame_tracker          tracker;
	logic [CFG_DATA_W-1:0] plan [NUM_TIMINGS];
	int                    sent_items;
	int                    cycle_count;
	bit                    send_rush;
	bit                    take_rush;
	bit                    dense;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int draw_gap(bit rush);
		return rush ? 0 : int'($urandom_range(0, 10));
	endfunction

	function automatic logic [15:0] pick_mark(bit short_only);
		int r;
		r = $urandom_range(0, 19);
		if (short_only || r < 10)
			return 16'($urandom_range(0, CARRIER_PERIOD - 1));
		else if (r < 17)
			return 16'($urandom_range(CARRIER_PERIOD, 2 * CARRIER_PERIOD - 1));
		else
			return 16'($urandom_range(2 * CARRIER_PERIOD, 3 * CARRIER_PERIOD - 1));
	endfunction

	function automatic logic [15:0] pick_space();
		return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		if (!dense)
			return COUNT_W'($urandom_range(0, 5));
		return ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 63)) :
			COUNT_W'($urandom_range(0, 12));
	endfunction

	task automatic pick_plan();
		plan[REG_START_MARK]  = pick_mark(1'b0);
		plan[REG_START_SPACE] = pick_space();
		plan[REG_BIT_MARK]    = pick_mark(dense);
		plan[REG_ONE_SPACE]   = pick_space();
		plan[REG_ZERO_SPACE]  = pick_space();
		plan[REG_END_MARK]    = pick_mark(1'b0);
		plan[REG_END_SPACE]   = pick_space();
	endtask

	task automatic put_item(logic op, logic [CODE_W-1:0] code, logic [COUNT_W-1:0] count);
		int       gap;
		in_item_t it;
		it.op        = op;
		it.code_word = code;
		it.bit_count = count;
		gap = draw_gap(send_rush);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		tracker.take_item(it);
		sent_items++;
	endtask

	task automatic put_tick();
		put_item(OP_TICK, $urandom, COUNT_W'($urandom_range(0, 63)));
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timing(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= {idx, val};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		tracker.write_timing(idx, val);
	endtask

	task automatic close_writes();
		cfg_ch.valid <= 1'b0;
		repeat (3) @(posedge clk);
	endtask

	task automatic program_plan(bit with_unused);
		for (int i = 0; i < NUM_TIMINGS; i++)
			write_timing(cfg_reg_t'(i), plan[i]);
		if (with_unused)
			write_timing(REG_UNUSED, CFG_DATA_W'($urandom));
		close_writes();
	endtask

	task automatic run_frame(logic [CODE_W-1:0] code, logic [COUNT_W-1:0] count, bit retime);
		int steps;
		int cut;
		put_item(OP_SEND, code, count);
		cut   = retime ? int'($urandom_range(1, 40)) : -1;
		steps = 0;
		while (tracker.sending()) begin
			if ($urandom_range(0, 29) == 0)
				put_item(OP_SEND, $urandom, COUNT_W'($urandom_range(0, 63)));
			else
				put_tick();
			steps++;
			if (steps == cut) begin
				drain();
				pick_plan();
				program_plan(1'b0);
			end
		end
		repeat ($urandom_range(0, 2)) put_tick();
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int gap;
		result_ch.ready <= 1'b0;
		repeat (12) @(posedge clk);
		forever begin
			gap = draw_gap(take_rush);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			tracker.match_result(result_ch.data);
		end
	end

	initial begin
		tracker    = new();
		sent_items = 0;
		send_rush  = 1'b0;
		take_rush  = 1'b0;
		dense      = 1'b1;
		arst_n        <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.data   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_tick();
		drain();
		plan = '{default: 16'd0};
		program_plan(1'b1);
		put_item(OP_SEND, 32'hFFFF_FFFF, 6'd63);
		put_tick();
		drain();
		plan = '{16'd25, 16'd1, 16'd25, 16'd2, 16'd0, 16'd26, 16'd1};
		program_plan(1'b0);
		put_item(OP_SEND, 32'hFFFF_FFF5, 6'd3);
		put_tick();
		put_item(OP_SEND, $urandom, 6'd32);
		put_tick();
		drain();
		write_timing(REG_ONE_SPACE, 16'd3);
		close_writes();
		while (tracker.sending()) put_tick();
		put_tick();

		while (sent_items < RANDOM_ITEMS) begin
			drain();
			dense = ($urandom_range(0, 1) == 1);
			pick_plan();
			program_plan($urandom_range(0, 3) == 0);
			send_rush = ($urandom_range(0, 3) == 0);
			take_rush = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 6)) begin
				run_frame($urandom, pick_count(), $urandom_range(0, 9) == 0);
				if ($urandom_range(0, 4) == 0)
					drain();
			end
		end

		drain();
		plan = '{default: 16'hFFFF};
		program_plan(1'b1);
		send_rush = 1'b1;
		take_rush = 1'b1;
		put_item(OP_SEND, $urandom, 6'd63);
		repeat (60) put_tick();
		put_item(OP_SEND, $urandom, COUNT_W'($urandom_range(0, 63)));
		put_tick();
		drain();

		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
